[sv/websocket_frame_parser_defines.svh]
// Assertion macros for the frame parser block.
// Included by the modules that check their own logic; needs clk and arst_n in scope.
`ifndef WEBSOCKET_FRAME_PARSER_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH

// cond must never hold at a clock edge out of reset
`define WFP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante at one edge implies cons at the next
`define WFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WFP_ASSERT_NEVER(lbl, cond, msg)

`define WFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/wfp_pkg.sv]
// Shared types and constants of the frame parser block.
// No dependencies; used by every module of the block.
package wfp_pkg;

	localparam int WFP_QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_HEADER  = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_PAYLOAD = 2'd2;
	localparam logic [1:0] ST_DISCARD = 2'd3;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] OPC_RSVD_DATA_LO = 4'h3;
	localparam logic [3:0] OPC_RSVD_DATA_HI = 4'h8;
	localparam logic [3:0] OPC_LAST_CTRL    = 4'hB;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  data;
		logic [7:0]  key_byte;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic        last;
	} wfp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wfp_qstat_t;

endpackage

[sv/wfp_front.sv]
// Header parser: tracks the frame phase one byte per transfer and classifies it.
// Depends on wfp_pkg and websocket_frame_parser_defines.svh.
`include "websocket_frame_parser_defines.svh"

module wfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	output wfp_pkg::wfp_entry_t entry
);
	import wfp_pkg::*;

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DISCARD = 3'd5;

	logic [2:0]  phase_q, phase_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        mask_q, mask_n;
	logic [63:0] length_q, length_n;
	logic [2:0]  hcount_q, hcount_n;
	logic [31:0] key_q, key_n;
	logic [63:0] remain_q, remain_n;
	logic [1:0]  kidx_q, kidx_n;

	logic [1:0]  status;
	logic        last;
	logic        len_known;
	logic        hdr_done;
	logic [7:0]  key_sel;
	logic [63:0] remain_dec;

	always_comb begin
		case (kidx_q)
			2'd0: key_sel = key_q[31:24];
			2'd1: key_sel = key_q[23:16];
			2'd2: key_sel = key_q[15:8];
			default: key_sel = key_q[7:0];
		endcase
	end

	assign remain_dec = remain_q - {63'd0, (remain_q != 64'd0)};

	always_comb begin
		phase_n   = phase_q;
		fin_n     = fin_q;
		opcode_n  = opcode_q;
		mask_n    = mask_q;
		length_n  = length_q;
		hcount_n  = hcount_q;
		key_n     = key_q;
		remain_n  = remain_q;
		kidx_n    = kidx_q;
		status    = ST_HEADER;
		last      = 1'b0;
		len_known = 1'b0;
		hdr_done  = 1'b0;
		if (restart || phase_q == PH_FIRST || phase_q > PH_DISCARD) begin
			fin_n    = data_byte[7];
			opcode_n = data_byte[3:0];
			mask_n   = 1'b0;
			length_n = '0;
			hcount_n = '0;
			key_n    = '0;
			remain_n = '0;
			kidx_n   = '0;
			if ((opcode_n > OPC_RSVD_DATA_LO && opcode_n < OPC_RSVD_DATA_HI) ||
					opcode_n > OPC_LAST_CTRL) begin
				phase_n = PH_DISCARD;
				status  = ST_DISCARD;
			end else begin
				phase_n = PH_SECOND;
			end
		end else begin
			case (phase_q)
				PH_SECOND: begin
					mask_n   = data_byte[7];
					hcount_n = '0;
					if (data_byte[6:0] == LEN_EXT16 || data_byte[6:0] == LEN_EXT64) begin
						length_n = '0;
						hcount_n = (data_byte[6:0] == LEN_EXT16) ? 3'd6 : 3'd0;
						phase_n  = PH_EXTLEN;
					end else begin
						length_n  = {57'd0, data_byte[6:0]};
						len_known = 1'b1;
					end
				end
				PH_EXTLEN: begin
					length_n = {length_q[55:0], data_byte};
					if (hcount_q == 3'd7) begin
						len_known = 1'b1;
					end else begin
						hcount_n = hcount_q + 3'd1;
					end
				end
				PH_KEY: begin
					key_n = {key_q[23:0], data_byte};
					if (hcount_q >= 3'd3) begin
						hcount_n = '0;
						hdr_done = 1'b1;
					end else begin
						hcount_n = hcount_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					status   = ST_PAYLOAD;
					kidx_n   = kidx_q + 2'd1;
					remain_n = remain_dec;
					if (remain_dec == 64'd0) begin
						last    = 1'b1;
						phase_n = PH_FIRST;
					end
				end
				default: begin
					status = ST_DISCARD;
				end
			endcase
			if (len_known) begin
				hcount_n = '0;
				if (mask_n) begin
					phase_n = PH_KEY;
				end else begin
					hdr_done = 1'b1;
				end
			end
			if (hdr_done) begin
				remain_n = length_n;
				kidx_n   = '0;
				status   = ST_DONE;
				if (length_n == 64'd0) begin
					last    = 1'b1;
					phase_n = PH_FIRST;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			length_q <= '0;
			hcount_q <= '0;
			key_q    <= '0;
			remain_q <= '0;
			kidx_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			length_q <= length_n;
			hcount_q <= hcount_n;
			key_q    <= key_n;
			remain_q <= remain_n;
			kidx_q   <= kidx_n;
		end
	end

	always_comb begin
		entry.status   = status;
		entry.data     = data_byte;
		entry.key_byte = (status == ST_PAYLOAD) ? key_sel : 8'd0;
		entry.fin      = fin_n;
		entry.opcode   = opcode_n;
		entry.masked   = mask_n;
		entry.length   = length_n;
		entry.last     = last;
	end

	`WFP_ASSERT_NEXT(a_discard_hold, accept && !restart && phase_q == PH_DISCARD, phase_q == PH_DISCARD, "discarding frame left discard without restart")
	`WFP_ASSERT_NEVER(a_last_kind, accept && last && status != ST_DONE && status != ST_PAYLOAD, "last flagged on a byte that ends nothing")
	`WFP_ASSERT_NEVER(a_payload_len, phase_q == PH_PAYLOAD && remain_q == 64'd0, "payload phase with no bytes left")

endmodule

[sv/wfp_queue.sv]
// Short queue of classified bytes between the parser and the output stage.
// Depends on wfp_pkg and websocket_frame_parser_defines.svh.
`include "websocket_frame_parser_defines.svh"

module wfp_queue #(
	parameter int DEPTH = wfp_pkg::WFP_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wfp_pkg::wfp_entry_t wr_entry,
	input  logic                pop,
	output wfp_pkg::wfp_entry_t rd_entry,
	output wfp_pkg::wfp_qstat_t qstat
);
	import wfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wfp_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign rd_entry    = slot_q[rptr_q];
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	`WFP_ASSERT_NEVER(a_overflow, push && qstat.full, "push into full queue")
	`WFP_ASSERT_NEVER(a_underflow, pop && qstat.empty, "pop from empty queue")
	`WFP_ASSERT_NEVER(a_count, cnt_q > CNT_W'(DEPTH), "queue count past depth")

endmodule

[sv/wfp_back.sv]
// Output stage: unmasks payload bytes and holds the result until it transfers.
// Depends on wfp_pkg and websocket_frame_parser_defines.svh.
`include "websocket_frame_parser_defines.svh"

module wfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wfp_pkg::wfp_entry_t rd_entry,
	input  wfp_pkg::wfp_qstat_t qstat,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          status,
	output logic [7:0]          payload_byte,
	output logic                fin,
	output logic [3:0]          opcode,
	output logic                masked,
	output logic [63:0]         payload_length,
	output logic                last
);
	import wfp_pkg::*;

	logic        valid_q;
	logic [1:0]  status_q;
	logic [7:0]  pbyte_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] length_q;
	logic        last_q;

	assign pop = !qstat.empty && (!valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= rd_entry.status;
			pbyte_q  <= (rd_entry.status == ST_PAYLOAD) ?
				(rd_entry.data ^ rd_entry.key_byte) : 8'd0;
			fin_q    <= rd_entry.fin;
			opcode_q <= rd_entry.opcode;
			masked_q <= rd_entry.masked;
			length_q <= rd_entry.length;
			last_q   <= rd_entry.last;
		end
	end

	assign result_valid   = valid_q;
	assign status         = status_q;
	assign payload_byte   = pbyte_q;
	assign fin            = fin_q;
	assign opcode         = opcode_q;
	assign masked         = masked_q;
	assign payload_length = length_q;
	assign last           = last_q;

	`WFP_ASSERT_NEVER(a_no_overwrite, pop && valid_q && result_stall, "held result overwritten")
	`WFP_ASSERT_NEVER(a_pbyte_zero, valid_q && status_q != ST_PAYLOAD && pbyte_q != 8'd0, "payload byte set outside payload")
	`WFP_ASSERT_NEXT(a_hold_valid, valid_q && result_stall, valid_q, "stalled result dropped")

endmodule

[sv/websocket_frame_parser.sv]
// Frame header parser and payload unmasker. One frame byte is taken per transfer
// and exactly one result leaves per byte, in order. Throughput is one byte per clock
// while frame_stall is low; the parser updates its header state at each transfer. A
// result is written to a queue slot at its byte's transfer, then to the output register
// once that register is free. The parser keeps taking bytes while results wait, and
// stalls once QUEUE_DEPTH results are queued behind the one held at the output.
// Depends on wfp_pkg, wfp_front, wfp_queue and wfp_back.

module websocket_frame_parser #(
	parameter int QUEUE_DEPTH = wfp_pkg::WFP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [7:0]  payload_byte,
	output logic        fin,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] payload_length,
	output logic        last
);
	import wfp_pkg::*;

	logic       accept;
	logic       pop;
	wfp_entry_t wr_entry;
	wfp_entry_t rd_entry;
	wfp_qstat_t qstat;

	assign frame_stall = qstat.full;
	assign accept      = frame_valid && !qstat.full;

	wfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.restart   (restart),
		.entry     (wr_entry)
	);

	wfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.qstat    (qstat)
	);

	wfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd_entry       (rd_entry),
		.qstat          (qstat),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.payload_byte   (payload_byte),
		.fin            (fin),
		.opcode         (opcode),
		.masked         (masked),
		.payload_length (payload_length),
		.last           (last)
	);

endmodule
